// ----- design/rgbhsv_pkg.sv -----
package rgbhsv_pkg;

  // Which channel holds the maximum, and so which 60-degree sector applies.
  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_t;

  // Hue bookkeeping that rides alongside the division row.
  typedef struct packed {
    sector_t sector;
    logic    neg;
  } hue_ctl_t;

  localparam int HUE_BITS = 13;
  localparam int SAT_BITS = 8;
  localparam int BRI_BITS = 8;
  localparam int SAT_FULL = 255;

endpackage

// ----- design/rgbhsv_pix_if.sv -----
interface rgbhsv_pix_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ----- design/rgbhsv_hsv_if.sv -----
interface rgbhsv_hsv_if;
  logic                          valid;
  logic                          ready;
  logic [rgbhsv_pkg::HUE_BITS-1:0] hue;
  logic [rgbhsv_pkg::SAT_BITS-1:0] saturation;
  logic [rgbhsv_pkg::BRI_BITS-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                output ready);
endinterface

// ----- design/rgb_to_hsv_converter.sv -----
// Pipeline: a set-up stage for the extremum and numerators, one division cell per quotient
// bit (10 cells with the default 16 hue steps per degree), then the output register.
// Throughput: one pixel per clock while out_hsv.ready does not hold the pipeline back;
// every division cell is a pipeline stage of its own.
// Reset clears only the stage valid flags; the datapath registers are left as they are.
module rgb_to_hsv_converter #(
  parameter int CHANNEL_BITS         = 8,
  parameter int HUE_STEPS_PER_DEGREE = 16
) (
  input  logic clk,
  input  logic rst_n,
  rgbhsv_pix_if.sink   in_pix,
  rgbhsv_hsv_if.source out_hsv
);

  localparam int CB     = CHANNEL_BITS;
  localparam int SECTOR = 60 * HUE_STEPS_PER_DEGREE;
  localparam int CIRCLE = 360 * HUE_STEPS_PER_DEGREE;
  localparam int QH     = $clog2(SECTOR + 1);
  localparam int L      = (QH > rgbhsv_pkg::SAT_BITS) ? QH : rgbhsv_pkg::SAT_BITS;
  localparam int NSW    = CB + 9;
  localparam int NHW    = CB + QH + 1;
  localparam int DW     = CB + 1;
  localparam int HW     = QH + 3;

  // Stage 0 is the set-up stage, stages 1..L the division cells, stage L+1 the output.
  logic [L+1:0] stage_v;
  logic [L+2:0] stage_rdy;

  logic [NSW-1:0]                 ns_a  [0:L];
  logic [DW-1:0]                  ds_a  [0:L];
  logic [L-1:0]                   qs_a  [0:L];
  logic [NHW-1:0]                 nh_a  [0:L];
  logic [DW-1:0]                  dh_a  [0:L];
  logic [L-1:0]                   qh_a  [0:L];
  rgbhsv_pkg::hue_ctl_t           ctl_a [0:L];
  logic [rgbhsv_pkg::BRI_BITS-1:0] bri_a [0:L];
  logic [HW-1:0]                  hue_full;

  // A stage may load when it is empty or its successor is loading too.
  assign stage_rdy[L+2] = out_hsv.ready;
  for (genvar i = 0; i <= L + 1; i++) begin : g_rdy
    assign stage_rdy[i] = !stage_v[i] || stage_rdy[i+1];
  end

  assign in_pix.ready = stage_rdy[0];
  assign qs_a[0]      = '0;
  assign qh_a[0]      = '0;

  rgbhsv_prep #(
    .CB     (CB),
    .SECTOR (SECTOR),
    .NSW    (NSW),
    .NHW    (NHW),
    .DW     (DW)
  ) u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (stage_rdy[0]),
    .v_i   (in_pix.valid),
    .red   (in_pix.red),
    .green (in_pix.green),
    .blue  (in_pix.blue),
    .v_r   (stage_v[0]),
    .ns_r  (ns_a[0]),
    .ds_r  (ds_a[0]),
    .nh_r  (nh_a[0]),
    .dh_r  (dh_a[0]),
    .ctl_r (ctl_a[0]),
    .bri_r (bri_a[0])
  );

  for (genvar k = 1; k <= L; k++) begin : g_cell
    rgbhsv_div_cell #(
      .L     (L),
      .SHIFT (L - k),
      .NSW   (NSW),
      .NHW   (NHW),
      .DW    (DW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (stage_rdy[k]),
      .v_i   (stage_v[k-1]),
      .ns_i  (ns_a[k-1]),
      .ds_i  (ds_a[k-1]),
      .qs_i  (qs_a[k-1]),
      .nh_i  (nh_a[k-1]),
      .dh_i  (dh_a[k-1]),
      .qh_i  (qh_a[k-1]),
      .ctl_i (ctl_a[k-1]),
      .bri_i (bri_a[k-1]),
      .v_r   (stage_v[k]),
      .ns_r  (ns_a[k]),
      .ds_r  (ds_a[k]),
      .qs_r  (qs_a[k]),
      .nh_r  (nh_a[k]),
      .dh_r  (dh_a[k]),
      .qh_r  (qh_a[k]),
      .ctl_r (ctl_a[k]),
      .bri_r (bri_a[k])
    );
  end

  rgbhsv_post #(
    .L      (L),
    .SECTOR (SECTOR),
    .CIRCLE (CIRCLE),
    .HW     (HW)
  ) u_post (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (stage_rdy[L+1]),
    .v_i   (stage_v[L]),
    .qs_i  (qs_a[L]),
    .qh_i  (qh_a[L]),
    .ctl_i (ctl_a[L]),
    .bri_i (bri_a[L]),
    .v_r   (stage_v[L+1]),
    .hue_r (hue_full),
    .sat_r (out_hsv.saturation),
    .bri_r (out_hsv.brightness)
  );

  assign out_hsv.valid = stage_v[L+1];
  assign out_hsv.hue   = rgbhsv_pkg::HUE_BITS'(hue_full);

  // With the output register empty nothing can hold the pipeline back.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_hsv.valid |-> in_pix.ready)
    else $error("input stalled with empty output stage");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_hsv.valid)
    else $error("result offered straight after reset");

endmodule

// ----- design/rgbhsv_prep.sv -----
module rgbhsv_prep #(
  parameter int CB     = 8,
  parameter int SECTOR = 960,
  parameter int NSW    = 17,
  parameter int NHW    = 19,
  parameter int DW     = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          v_i,
  input  logic [CB-1:0]                 red,
  input  logic [CB-1:0]                 green,
  input  logic [CB-1:0]                 blue,
  output logic                          v_r,
  output logic [NSW-1:0]                ns_r,
  output logic [DW-1:0]                 ds_r,
  output logic [NHW-1:0]                nh_r,
  output logic [DW-1:0]                 dh_r,
  output rgbhsv_pkg::hue_ctl_t          ctl_r,
  output logic [rgbhsv_pkg::BRI_BITS-1:0] bri_r
);

  logic [CB-1:0]                 mx, mn, delta, op_a, op_b, diff;
  logic [NSW-1:0]                ns_nxt;
  logic [DW-1:0]                 ds_nxt, dh_nxt;
  logic [NHW-1:0]                nh_nxt;
  rgbhsv_pkg::hue_ctl_t          ctl_nxt;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;

    // Ties go to red first, then green.
    if (mx == red) begin
      ctl_nxt.sector = rgbhsv_pkg::SECTOR_RED;
    end else if (mx == green) begin
      ctl_nxt.sector = rgbhsv_pkg::SECTOR_GREEN;
    end else begin
      ctl_nxt.sector = rgbhsv_pkg::SECTOR_BLUE;
    end

    case (ctl_nxt.sector)
      rgbhsv_pkg::SECTOR_GREEN: begin
        op_a = blue;
        op_b = red;
      end
      rgbhsv_pkg::SECTOR_BLUE: begin
        op_a = red;
        op_b = green;
      end
      default: begin
        op_a = green;
        op_b = blue;
      end
    endcase

    ctl_nxt.neg = (op_a < op_b);
    diff        = ctl_nxt.neg ? (op_b - op_a) : (op_a - op_b);

    // Numerators carry the half-divisor so that a floor division rounds.
    // A zero divisor is replaced by one with a zero numerator, giving zero.
    if (delta == '0) begin
      nh_nxt = '0;
      dh_nxt = DW'(1);
    end else begin
      nh_nxt = NHW'(diff) * NHW'(2 * SECTOR) + NHW'(delta);
      dh_nxt = {delta, 1'b0};
    end

    ns_nxt = NSW'(delta) * NSW'(2 * rgbhsv_pkg::SAT_FULL) + NSW'(mx);
    ds_nxt = (mx == '0) ? DW'(1) : {mx, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ns_r  <= ns_nxt;
      ds_r  <= ds_nxt;
      nh_r  <= nh_nxt;
      dh_r  <= dh_nxt;
      ctl_r <= ctl_nxt;
      bri_r <= rgbhsv_pkg::BRI_BITS'(mx);
    end
  end

endmodule

// ----- design/rgbhsv_div_cell.sv -----
module rgbhsv_div_cell #(
  parameter int L     = 10,
  parameter int SHIFT = 9,
  parameter int NSW   = 17,
  parameter int NHW   = 19,
  parameter int DW    = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          v_i,
  input  logic [NSW-1:0]                ns_i,
  input  logic [DW-1:0]                 ds_i,
  input  logic [L-1:0]                  qs_i,
  input  logic [NHW-1:0]                nh_i,
  input  logic [DW-1:0]                 dh_i,
  input  logic [L-1:0]                  qh_i,
  input  rgbhsv_pkg::hue_ctl_t          ctl_i,
  input  logic [rgbhsv_pkg::BRI_BITS-1:0] bri_i,
  output logic                          v_r,
  output logic [NSW-1:0]                ns_r,
  output logic [DW-1:0]                 ds_r,
  output logic [L-1:0]                  qs_r,
  output logic [NHW-1:0]                nh_r,
  output logic [DW-1:0]                 dh_r,
  output logic [L-1:0]                  qh_r,
  output rgbhsv_pkg::hue_ctl_t          ctl_r,
  output logic [rgbhsv_pkg::BRI_BITS-1:0] bri_r
);

  localparam int SW = NSW + L;
  localparam int HW = NHW + L;

  logic [SW-1:0]  s_rem_x, s_div_x;
  logic [HW-1:0]  h_rem_x, h_div_x;
  logic           s_ge, h_ge;
  logic [NSW-1:0] ns_nxt;
  logic [NHW-1:0] nh_nxt;
  logic [L-1:0]   qs_nxt, qh_nxt;

  // One restoring step on each lane: try the divisor at this cell's weight.
  always_comb begin
    s_rem_x = SW'(ns_i);
    s_div_x = SW'(ds_i) << SHIFT;
    s_ge    = (s_rem_x >= s_div_x);
    ns_nxt  = s_ge ? NSW'(s_rem_x - s_div_x) : ns_i;
    qs_nxt  = {qs_i[L-2:0], s_ge};

    h_rem_x = HW'(nh_i);
    h_div_x = HW'(dh_i) << SHIFT;
    h_ge    = (h_rem_x >= h_div_x);
    nh_nxt  = h_ge ? NHW'(h_rem_x - h_div_x) : nh_i;
    qh_nxt  = {qh_i[L-2:0], h_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ns_r  <= ns_nxt;
      ds_r  <= ds_i;
      qs_r  <= qs_nxt;
      nh_r  <= nh_nxt;
      dh_r  <= dh_i;
      qh_r  <= qh_nxt;
      ctl_r <= ctl_i;
      bri_r <= bri_i;
    end
  end

  // After this step the partial remainder must lie below the divisor at this weight.
  a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> (SW'(ns_r) < (SW'(ds_r) << SHIFT)) && (HW'(nh_r) < (HW'(dh_r) << SHIFT)))
    else $error("division remainder out of range");

endmodule

// ----- design/rgbhsv_post.sv -----
module rgbhsv_post #(
  parameter int L      = 10,
  parameter int SECTOR = 960,
  parameter int CIRCLE = 5760,
  parameter int HW     = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          v_i,
  input  logic [L-1:0]                  qs_i,
  input  logic [L-1:0]                  qh_i,
  input  rgbhsv_pkg::hue_ctl_t          ctl_i,
  input  logic [rgbhsv_pkg::BRI_BITS-1:0] bri_i,
  output logic                          v_r,
  output logic [HW-1:0]                 hue_r,
  output logic [rgbhsv_pkg::SAT_BITS-1:0] sat_r,
  output logic [rgbhsv_pkg::BRI_BITS-1:0] bri_r
);

  logic [HW-1:0] off, hue_nxt;

  always_comb begin
    off = HW'(qh_i);
    case (ctl_i.sector)
      rgbhsv_pkg::SECTOR_GREEN: begin
        hue_nxt = ctl_i.neg ? HW'(2 * SECTOR) - off : HW'(2 * SECTOR) + off;
      end
      rgbhsv_pkg::SECTOR_BLUE: begin
        hue_nxt = ctl_i.neg ? HW'(4 * SECTOR) - off : HW'(4 * SECTOR) + off;
      end
      default: begin
        // A negative red offset wraps round the full circle.
        hue_nxt = (ctl_i.neg && off != '0) ? HW'(CIRCLE) - off : off;
        if (hue_nxt >= HW'(CIRCLE)) hue_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r <= hue_nxt;
      sat_r <= rgbhsv_pkg::SAT_BITS'(qs_i);
      bri_r <= bri_i;
    end
  end

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> hue_r < HW'(CIRCLE))
    else $error("hue beyond full circle");

endmodule

// ----- verif/tb_rgb_to_hsv_converter.sv -----
`timescale 1ns / 100ps

module tb_rgb_to_hsv_converter;

  localparam int CHAN_BITS        = 8;
  localparam int HUE_STEPS        = 16;
  localparam int SECTOR_STEPS     = 60 * HUE_STEPS;
  localparam int CIRCLE_STEPS     = 360 * HUE_STEPS;
  localparam int PIPE_LATENCY     = 11;
  localparam int IDLE_LIMIT       = 2000;
  localparam int RANDOM_PER_PHASE = 510;
  localparam int MAX_REPORTS      = 10;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [rgbhsv_pkg::HUE_BITS-1:0] hue;
    logic [rgbhsv_pkg::SAT_BITS-1:0] saturation;
    logic [rgbhsv_pkg::BRI_BITS-1:0] brightness;
  } hsv_t;

  logic clk;
  logic rst_n;

  rgbhsv_pix_if #(.CHANNEL_BITS(CHAN_BITS)) pix_bus ();
  rgbhsv_hsv_if hsv_bus ();

  rgb_to_hsv_converter #(
    .CHANNEL_BITS         (CHAN_BITS),
    .HUE_STEPS_PER_DEGREE (HUE_STEPS)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_bus),
    .out_hsv (hsv_bus)
  );

  rgb_t        pixel_q[$];
  hsv_t        expected_hsv[$];
  rgb_t        next_pix;
  hsv_t        got_hsv;
  hsv_t        want_hsv;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int          pixels_sent = 0;
  int          results_checked = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          pix_fired;

  // Hue, saturation and value of one pixel, rounded half away from zero.
  function automatic hsv_t predict_hsv(input logic [CHAN_BITS-1:0] r, g, b);
    hsv_t                res;
    rgbhsv_pkg::sector_t sec;
    int                  ri, gi, bi, mx, mn, delta, num_a, num_b, diff, off, base;
    int                  hue_val, sat_val;
    bit                  neg;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    mx = ri;
    mn = ri;
    if (gi > mx) mx = gi;
    if (bi > mx) mx = bi;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    delta = mx - mn;
    sat_val = (mx == 0) ? 0 : (2 * rgbhsv_pkg::SAT_FULL * delta + mx) / (2 * mx);
    res.brightness = rgbhsv_pkg::BRI_BITS'(mx);
    res.saturation = rgbhsv_pkg::SAT_BITS'(sat_val);
    res.hue = '0;
    if (delta != 0) begin
      if (mx == ri) sec = rgbhsv_pkg::SECTOR_RED;
      else if (mx == gi) sec = rgbhsv_pkg::SECTOR_GREEN;
      else sec = rgbhsv_pkg::SECTOR_BLUE;
      case (sec)
        rgbhsv_pkg::SECTOR_RED: begin
          num_a = gi;
          num_b = bi;
          base  = 0;
        end
        rgbhsv_pkg::SECTOR_GREEN: begin
          num_a = bi;
          num_b = ri;
          base  = 2 * SECTOR_STEPS;
        end
        default: begin
          num_a = ri;
          num_b = gi;
          base  = 4 * SECTOR_STEPS;
        end
      endcase
      neg  = num_a < num_b;
      diff = neg ? num_b - num_a : num_a - num_b;
      off  = (2 * SECTOR_STEPS * diff + delta) / (2 * delta);
      hue_val = neg ? base - off : base + off;
      // Only the red sector can go below zero; no sector reaches the full circle.
      if (hue_val < 0) hue_val += CIRCLE_STEPS;
      if (hue_val >= CIRCLE_STEPS) hue_val = 0;
      res.hue = rgbhsv_pkg::HUE_BITS'(hue_val);
    end
    return res;
  endfunction

  task automatic log_mismatch(input string what, input hsv_t want, input hsv_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s: expected hue %0d sat %0d val %0d, got hue %0d sat %0d val %0d",
               $time, what, want.hue, want.saturation, want.brightness,
               got.hue, got.saturation, got.brightness);
    end
  endtask

  task automatic queue_pixel(input logic [CHAN_BITS-1:0] r, g, b);
    rgb_t pix;
    pix.red   = r;
    pix.green = g;
    pix.blue  = b;
    pixel_q.push_back(pix);
  endtask

  // Uniform pixels half the time, greys and tied maxima the other half, often enough
  // that the tie-break paths see plenty of traffic.
  task automatic queue_random_pixels(input int count);
    logic [CHAN_BITS-1:0] top, other;
    int                   kind;
    repeat (count) begin
      kind  = $urandom_range(7);
      top   = CHAN_BITS'($urandom);
      other = CHAN_BITS'($urandom_range(top));
      case (kind)
        0: queue_pixel(top, top, top);
        1: queue_pixel(top, top, other);
        2: queue_pixel(other, top, top);
        3: queue_pixel(top, other, top);
        default: queue_pixel(CHAN_BITS'($urandom), CHAN_BITS'($urandom),
                             CHAN_BITS'($urandom));
      endcase
    end
  endtask

  // The sender holds off until every pixel is across and every result is back.
  task automatic wait_all_drained();
    while (pixel_q.size() != 0 || pix_bus.valid || expected_hsv.size() != 0)
      @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      pix_bus.valid <= 1'b0;
      pix_bus.red   <= '0;
      pix_bus.green <= '0;
      pix_bus.blue  <= '0;
      hsv_bus.ready <= 1'b0;
    end else begin
      hsv_bus.ready <= ($urandom_range(99) >= stall_pct);
      if (!pix_bus.valid || pix_fired) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_pix = pixel_q.pop_front();
          pix_bus.valid <= 1'b1;
          pix_bus.red   <= next_pix.red;
          pix_bus.green <= next_pix.green;
          pix_bus.blue  <= next_pix.blue;
        end else begin
          pix_bus.valid <= 1'b0;
          pix_bus.red   <= CHAN_BITS'($urandom);
          pix_bus.green <= CHAN_BITS'($urandom);
          pix_bus.blue  <= CHAN_BITS'($urandom);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pix_fired <= 1'b0;
    end else begin
      pix_fired <= pix_bus.valid && pix_bus.ready;
      if (pix_bus.valid && pix_bus.ready) begin
        expected_hsv.push_back(predict_hsv(pix_bus.red, pix_bus.green, pix_bus.blue));
        pixels_sent++;
      end
      if (hsv_bus.valid && hsv_bus.ready) begin
        got_hsv.hue        = hsv_bus.hue;
        got_hsv.saturation = hsv_bus.saturation;
        got_hsv.brightness = hsv_bus.brightness;
        results_checked++;
        if (expected_hsv.size() == 0) begin
          log_mismatch("result with nothing outstanding", 'x, got_hsv);
        end else begin
          want_hsv = expected_hsv.pop_front();
          if (got_hsv.hue !== want_hsv.hue || got_hsv.saturation !== want_hsv.saturation ||
              got_hsv.brightness !== want_hsv.brightness) begin
            log_mismatch("HSV mismatch", want_hsv, got_hsv);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((pix_bus.valid && pix_bus.ready) || (hsv_bus.valid && hsv_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    send_idle_pct   = 16;
    stall_pct       = 49;
    wait (rst_n === 1'b1);
    @(posedge clk);

    // Black, white, grey, primaries, tied maxima and rounding halves.
    queue_pixel(8'd0,   8'd0,   8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd128, 8'd128, 8'd128);
    queue_pixel(8'd255, 8'd0,   8'd0);
    queue_pixel(8'd0,   8'd255, 8'd0);
    queue_pixel(8'd0,   8'd0,   8'd255);
    queue_pixel(8'd255, 8'd255, 8'd0);
    queue_pixel(8'd0,   8'd255, 8'd255);
    queue_pixel(8'd255, 8'd0,   8'd255);
    queue_pixel(8'd255, 8'd0,   8'd1);
    queue_pixel(8'd1,   8'd0,   8'd0);
    queue_pixel(8'd0,   8'd1,   8'd0);
    queue_pixel(8'd0,   8'd0,   8'd1);
    queue_pixel(8'd2,   8'd1,   8'd1);
    queue_pixel(8'd255, 8'd128, 8'd127);
    queue_pixel(8'd255, 8'd127, 8'd128);
    queue_pixel(8'd127, 8'd255, 8'd128);
    queue_pixel(8'd128, 8'd255, 8'd127);
    queue_pixel(8'd128, 8'd127, 8'd255);
    queue_pixel(8'd127, 8'd128, 8'd255);
    queue_pixel(8'd170, 8'd85,  8'd255);
    queue_pixel(8'd254, 8'd1,   8'd127);
    wait_all_drained();

    queue_random_pixels(RANDOM_PER_PHASE);
    wait_all_drained();

    send_idle_pct = 49;
    stall_pct     = 16;
    queue_random_pixels(RANDOM_PER_PHASE);
    wait_all_drained();

    send_idle_pct = 0;
    stall_pct     = 0;
    queue_random_pixels(RANDOM_PER_PHASE);
    wait_all_drained();

    repeat (4 * PIPE_LATENCY) @(posedge clk);
    if (expected_hsv.size() != 0) begin
      $display("%0d results never arrived", expected_hsv.size());
    end
    $display("Converted %0d pixels (corner cases, greys, tied maxima, random colours) and",
             pixels_sent);
    $display("checked %0d results under sender gaps, receiver stalls and full rate: %0d bad",
             results_checked, mismatches);
    if (mismatches == 0 && expected_hsv.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
